### sv/ipatc_pkg.sv
// shared types, character codes and helpers of the address text classifier
`default_nettype none

package ipatc_pkg;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	// counter limits
	localparam int DIG_W   = 3;
	localparam int OCT_W   = 9;
	localparam int DOTS_W  = 3;
	localparam int COL_W   = 4;
	localparam int DBL_W   = 2;

	localparam logic [DIG_W-1:0]  DIG_MAX    = '1;
	localparam logic [OCT_W-1:0]  OCT_MAX    = '1;
	localparam logic [DOTS_W-1:0] DOTS_MAX   = '1;
	localparam logic [COL_W-1:0]  COL_MAX    = '1;
	localparam logic [DBL_W-1:0]  DBL_MAX    = '1;
	localparam logic [OCT_W-1:0]  OCT_LIMIT  = 9'd255;
	localparam logic [DIG_W-1:0]  QUAD_DIGS  = 3'd3;
	localparam logic [DOTS_W-1:0] QUAD_DOTS  = 3'd3;
	localparam logic [DIG_W-1:0]  HEX_DIGS   = 3'd4;
	localparam logic [COL_W-1:0]  COL_FULL   = 4'd7;
	localparam logic [COL_W-1:0]  COL_MIN    = 4'd2;

	// register map
	localparam int PADDR_W = 3;
	localparam logic REG_IPV6_EN = 1'b0;

	// result kinds
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_IPV4 = 2'd1,
		KIND_IPV6 = 2'd2
	} kind_t;

	// checker control: feed a character or return to the start
	typedef struct packed {
		logic feed;
		logic clear;
	} chk_ctl_t;

	// hex/colon checker summary
	typedef struct packed {
		logic base_ok;
		logic hex_only;
		logic tail_allowed;
	} hex_stat_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
	endfunction

endpackage

`default_nettype wire

### sv/ip_address_text_classifier.sv
// top level: input register, three checkers, result register and config port
//
// Classifies an address string given one character per transfer on the
// s_tvalid/s_tready/s_tdata channel; a zero character ends the string.
// For each string exactly one result transfer leaves on m_tvalid/m_tready/
// m_tdata with the kind: 0 not an address, 1 IPv4, 2 IPv6.
// Throughput is one character per cycle while no terminator waits for the
// output register. A character is first held in the input register and
// then updates the three checkers; the result of a terminating zero goes
// from the input register into the output register and leaves from there.
// While a result waits in the output register and m_tready is low, plain
// characters still move through; only a following terminator waits in the
// input register, and s_tready drops behind it.
// The APB port holds ipv6_enable at byte address 0 (bit 0); write it only
// while no string is in flight.
// Reset clears all checker state, empties both registers and sets
// ipv6_enable to 1. After each terminator the checkers restart.
`default_nettype none

module ip_address_text_classifier (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input stream
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,   // [7:0] ch
	// result stream
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [7:0]                        m_tdata,   // [1:0] kind, [7:2] zero
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ipatc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import ipatc_pkg::*;

	logic      ipv6_en_q;
	logic      valid_s1;
	logic [7:0] ch_s1;
	logic      m_valid_q;
	kind_t     kind_q;

	logic      term;
	logic      adv;
	chk_ctl_t  quad_ctl;
	chk_ctl_t  tail_ctl;
	chk_ctl_t  hex_ctl;
	logic      quad_ok;
	logic      tail_ok;
	hex_stat_t hex_stat;
	kind_t     kind_next;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv6_en_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2] == REG_IPV6_EN) begin
			ipv6_en_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_IPV6_EN) ? {31'd0, ipv6_en_q} : 32'd0;

	// stage control: a terminator needs room in the output register
	always_comb begin
		term     = (ch_s1 == CH_NUL);
		adv      = valid_s1 && (!term || !m_valid_q || m_tready);
		s_tready = !valid_s1 || adv;

		quad_ctl.feed  = adv && !term;
		quad_ctl.clear = adv && term;
		tail_ctl.feed  = adv && !term && (ch_s1 != CH_COLON);
		tail_ctl.clear = adv && (term || ch_s1 == CH_COLON);
		hex_ctl        = quad_ctl;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) ch_s1 <= s_tdata;
	end

	ipatc_quad u_quad (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (quad_ctl),
		.ch     (ch_s1),
		.ok     (quad_ok)
	);

	ipatc_quad u_tail (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tail_ctl),
		.ch     (ch_s1),
		.ok     (tail_ok)
	);

	ipatc_hex u_hex (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hex_ctl),
		.ch     (ch_s1),
		.stat   (hex_stat)
	);

	// final decision, IPv4 first
	always_comb begin
		if (quad_ok) begin
			kind_next = KIND_IPV4;
		end else if (ipv6_en_q && hex_stat.base_ok
		             && (hex_stat.hex_only || (hex_stat.tail_allowed && tail_ok))) begin
			kind_next = KIND_IPV6;
		end else begin
			kind_next = KIND_NONE;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && term) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (adv && term) kind_q <= kind_next;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, kind_q};

endmodule

`default_nettype wire

### sv/ipatc_quad.sv
// dotted-quad checker: digit, octet and dot tracking with halt
`default_nettype none

module ipatc_quad (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ipatc_pkg::chk_ctl_t ctl,
	input  wire logic [7:0]         ch,
	output logic                    ok
);
	import ipatc_pkg::*;

	logic [DIG_W-1:0]  dig_q;
	logic [OCT_W-1:0]  oct_q;
	logic [DOTS_W-1:0] dots_q;
	logic              halt_q;

	logic [OCT_W+3:0]  oct_next;
	logic              oct_bad;

	// octet times ten plus the new digit, saturated
	always_comb begin
		oct_next = ({4'd0, oct_q} << 3) + ({4'd0, oct_q} << 1) + {9'd0, ch[3:0] - CH_ZERO[3:0]};
		oct_bad  = (oct_q > OCT_LIMIT);
	end

	// checker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q  <= '0;
			oct_q  <= '0;
			dots_q <= '0;
			halt_q <= 1'b0;
		end else if (ctl.clear) begin
			dig_q  <= '0;
			oct_q  <= '0;
			dots_q <= '0;
			halt_q <= 1'b0;
		end else if (ctl.feed && !halt_q) begin
			if (is_dec(ch)) begin
				oct_q <= (oct_next > {4'd0, OCT_MAX}) ? OCT_MAX : oct_next[OCT_W-1:0];
				if (dig_q != DIG_MAX) dig_q <= dig_q + 1'b1;
			end else if (ch == CH_DOT) begin
				if (dig_q == '0 || dig_q > QUAD_DIGS || oct_bad) begin
					halt_q <= 1'b1;
				end else begin
					dig_q <= '0;
					oct_q <= '0;
					if (dots_q != DOTS_MAX) dots_q <= dots_q + 1'b1;
				end
			end else begin
				dig_q  <= '0;
				halt_q <= 1'b1;
			end
		end
	end

	// complete address with four octets
	assign ok = (dots_q == QUAD_DOTS) && (dig_q != '0) && (dig_q <= QUAD_DIGS) && !oct_bad;

endmodule

`default_nettype wire

### sv/ipatc_hex.sv
// hex/colon checker allowing a single double colon
`default_nettype none

module ipatc_hex (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ipatc_pkg::chk_ctl_t ctl,
	input  wire logic [7:0]          ch,
	output ipatc_pkg::hex_stat_t     stat
);
	import ipatc_pkg::*;

	logic [DIG_W-1:0] dig_q;
	logic             hex_only_q;
	logic [COL_W-1:0] col_q;
	logic [DBL_W-1:0] dbl_q;
	logic             halt_q;
	logic             cah_q;

	logic             dbl_hit;
	logic [DBL_W-1:0] dbl_new;

	// a colon right after a colon counts as a double colon
	always_comb begin
		dbl_hit = (dig_q == '0) && (col_q != '0);
		dbl_new = (dbl_hit && dbl_q != DBL_MAX) ? dbl_q + 1'b1 : dbl_q;
	end

	// checker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q      <= '0;
			hex_only_q <= 1'b0;
			col_q      <= '0;
			dbl_q      <= '0;
			halt_q     <= 1'b0;
			cah_q      <= 1'b0;
		end else if (ctl.clear) begin
			dig_q      <= '0;
			hex_only_q <= 1'b0;
			col_q      <= '0;
			dbl_q      <= '0;
			halt_q     <= 1'b0;
			cah_q      <= 1'b0;
		end else if (ctl.feed) begin
			if (halt_q) begin
				if (ch == CH_COLON) cah_q <= 1'b1;
			end else if (is_hex(ch)) begin
				if (dig_q != DIG_MAX) dig_q <= dig_q + 1'b1;
				hex_only_q <= 1'b1;
			end else if (ch == CH_COLON) begin
				dbl_q <= dbl_new;
				if (dbl_hit) hex_only_q <= 1'b1;
				if (dig_q > HEX_DIGS || dbl_new > 2'd1) begin
					halt_q <= 1'b1;
				end else begin
					dig_q <= '0;
					if (col_q != COL_MAX) col_q <= col_q + 1'b1;
				end
			end else begin
				hex_only_q <= 1'b0;
				halt_q     <= 1'b1;
			end
		end
	end

	// summary for the final decision
	always_comb begin
		stat.base_ok      = (col_q >= COL_MIN) && (col_q <= COL_FULL) && (dbl_q <= 2'd1)
		                    && (dig_q <= HEX_DIGS);
		stat.hex_only     = hex_only_q;
		stat.tail_allowed = (col_q < COL_FULL) && !cah_q;
	end

endmodule

`default_nettype wire
